>>> src/pwrr_pkg.sv
// ----------------------------------------------------------------------------
// pwrr_pkg
// Shared types and constants for the per-user weighted round-robin scheduler.
// ----------------------------------------------------------------------------
package pwrr_pkg;

   localparam int MAX_USERS_DEF   = 16;
   localparam int QUEUE_DEPTH_DEF = 16;

   localparam int UID_W   = 16;
   localparam int WGT_W   = 8;
   localparam int PID_W   = 16;
   localparam int TICK_W  = 24;
   localparam int QB_W    = 16;
   localparam int ENTRY_W = PID_W + TICK_W;

   localparam logic [QB_W-1:0] QB_RESET = QB_W'(1);
   localparam logic [WGT_W-1:0] WGT_DEFAULT = WGT_W'(1);

   typedef enum logic [1:0] {
      REQ_ADD      = 2'd0,
      REQ_ENQUEUE  = 2'd1,
      REQ_DISPATCH = 2'd2,
      REQ_UNUSED   = 2'd3
   } req_code_type;

   typedef enum logic [2:0] {
      ST_ACCEPTED   = 3'd0,
      ST_DISPATCHED = 3'd1,
      ST_NONE_READY = 3'd2,
      ST_TABLE_FULL = 3'd3,
      ST_QUEUE_FULL = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOKUP,
      S_EXEC,
      S_SEARCH,
      S_READ,
      S_RESP
   } state_type;

endpackage

>>> src/pwrr_if.sv
// ----------------------------------------------------------------------------
// pwrr channel interfaces
// Request, response and CSR write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface pwrr_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    req_type;
   logic [pwrr_pkg::UID_W-1:0]    user_id;
   logic [pwrr_pkg::WGT_W-1:0]    weight;
   logic [pwrr_pkg::PID_W-1:0]    proc_id;
   logic [pwrr_pkg::TICK_W-1:0]   ticks_left;
   modport source (output valid, req_type, user_id, weight, proc_id, ticks_left,
                   input ready);
   modport sink   (input valid, req_type, user_id, weight, proc_id, ticks_left,
                   output ready);
endinterface

interface pwrr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [2:0]                    status;
   logic [pwrr_pkg::PID_W-1:0]    out_proc_id;
   logic [pwrr_pkg::UID_W-1:0]    out_user_id;
   logic [pwrr_pkg::TICK_W-1:0]   slice;
   modport source (output valid, status, out_proc_id, out_user_id, slice, input ready);
   modport sink   (input valid, status, out_proc_id, out_user_id, slice, output ready);
endinterface

interface pwrr_csr_if;
   logic                          valid;
   logic                          ready;
   logic [pwrr_pkg::QB_W-1:0]     slice_unit;
   modport source (output valid, slice_unit, input ready);
   modport sink   (input valid, slice_unit, output ready);
endinterface

>>> src/pwrr_ram.sv
// ----------------------------------------------------------------------------
// pwrr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pwrr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> src/per_user_weighted_round_robin.sv
// ----------------------------------------------------------------------------
// per_user_weighted_round_robin
// Per-user weighted round-robin scheduler with per-user process FIFOs.
// ----------------------------------------------------------------------------
// One request is handled at a time; req ready is high only while the block is
// idle with no response pending. An add or enqueue scans the user table one
// entry per cycle through a single id comparator, then performs the update in
// S_EXEC, followed by the response beat. A dispatch walks users round robin from
// the saved pointer, one per cycle, then takes the queue RAM read data
// (registered read) in S_READ and forms the slice, followed by the response
// beat. All queues share one RAM of MAX_USERS*QUEUE_DEPTH entries; no clearing
// pass is needed after reset.
module per_user_weighted_round_robin #(
   parameter int MAX_USERS   = pwrr_pkg::MAX_USERS_DEF,
   parameter int QUEUE_DEPTH = pwrr_pkg::QUEUE_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   pwrr_req_if.sink     req_bus,
   pwrr_rsp_if.source   rsp_bus,
   pwrr_csr_if.sink     csr_bus
);
   import pwrr_pkg::*;

   localparam int IW  = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
   localparam int UW  = $clog2(MAX_USERS + 1);
   localparam int PW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FW  = $clog2(QUEUE_DEPTH + 1);
   localparam int MD  = MAX_USERS * QUEUE_DEPTH;
   localparam int AW  = (MD > 1) ? $clog2(MD) : 1;

   state_type state_ff, state_in;

   logic [1:0]        type_ff, type_in;
   logic [UID_W-1:0]  uid_ff, uid_in;
   logic [WGT_W-1:0]  w_ff, w_in;
   logic [PID_W-1:0]  pid_ff, pid_in;
   logic [TICK_W-1:0] ticks_ff, ticks_in;
   logic [UW-1:0]     idx_ff, idx_in;
   logic [UW-1:0]     cnt_ff, cnt_in;
   logic              found_ff, found_in;
   logic [UW-1:0]     n_ff, n_in;
   logic [IW-1:0]     ptr_ff, ptr_in;
   logic [QB_W-1:0]   qb_ff, qb_in;
   logic [TICK_W-1:0] prod_ff, prod_in;
   status_type        status_ff, status_in;
   logic [PID_W-1:0]  opid_ff, opid_in;
   logic [UID_W-1:0]  ouid_ff, ouid_in;
   logic [TICK_W-1:0] slice_ff, slice_in;

   logic [UID_W-1:0]  uids_ff [MAX_USERS];
   logic [UID_W-1:0]  uids_in [MAX_USERS];
   logic [WGT_W-1:0]  wts_ff  [MAX_USERS];
   logic [WGT_W-1:0]  wts_in  [MAX_USERS];
   logic [FW-1:0]     fill_ff [MAX_USERS];
   logic [FW-1:0]     fill_in [MAX_USERS];
   logic [PW-1:0]     rdp_ff  [MAX_USERS];
   logic [PW-1:0]     rdp_in  [MAX_USERS];
   logic [PW-1:0]     wrp_ff  [MAX_USERS];
   logic [PW-1:0]     wrp_in  [MAX_USERS];

   logic [IW-1:0]      sel;
   logic [UW-1:0]      idx_next_wrap;
   logic               at_end;
   logic               id_match;
   logic               table_full;
   logic               queue_full;
   logic               sel_ready;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [AW-1:0]      mem_raddr;
   logic [ENTRY_W-1:0] mem_wdata;
   logic [ENTRY_W-1:0] mem_rdata;
   logic [PW-1:0]      wpos;
   logic [TICK_W-1:0]  rem;

   assign sel           = idx_ff[IW-1:0];
   assign at_end        = (idx_ff == n_ff);
   assign id_match      = (uids_ff[sel] == uid_ff);
   assign table_full    = (n_ff == UW'(MAX_USERS));
   assign queue_full    = (fill_ff[sel] == FW'(QUEUE_DEPTH));
   assign sel_ready     = (fill_ff[sel] != '0);
   assign idx_next_wrap = ((idx_ff + UW'(1)) == n_ff) ? '0 : idx_ff + UW'(1);
   assign wpos          = found_ff ? wrp_ff[sel] : '0;
   assign rem           = mem_rdata[ENTRY_W-1:PID_W];

   assign req_bus.ready = (state_ff == S_IDLE);
   assign csr_bus.ready = 1'b1;
   assign rsp_bus.valid       = (state_ff == S_RESP);
   assign rsp_bus.status      = status_ff;
   assign rsp_bus.out_proc_id = opid_ff;
   assign rsp_bus.out_user_id = ouid_ff;
   assign rsp_bus.slice       = slice_ff;

   assign mem_wdata = {ticks_ff, pid_ff};
   assign mem_waddr = AW'(sel) * AW'(QUEUE_DEPTH) + AW'(wpos);
   assign mem_raddr = AW'(sel) * AW'(QUEUE_DEPTH) + AW'(rdp_ff[sel]);
   assign mem_we    = (state_ff == S_EXEC) && (type_ff == REQ_ENQUEUE)
                      && (found_ff ? !queue_full : !table_full);

   pwrr_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MD)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               if (req_bus.req_type == REQ_ADD || req_bus.req_type == REQ_ENQUEUE) begin
                  state_in = S_LOOKUP;
               end else if (req_bus.req_type == REQ_DISPATCH && n_ff != '0) begin
                  state_in = S_SEARCH;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_LOOKUP: begin
            if (at_end || id_match) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: state_in = S_RESP;
         S_SEARCH: begin
            if (sel_ready) begin
               state_in = S_READ;
            end else if ((cnt_ff + UW'(1)) == n_ff) begin
               state_in = S_RESP;
            end
         end
         S_READ: state_in = S_RESP;
         S_RESP: begin
            if (rsp_bus.ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      type_in   = type_ff;
      uid_in    = uid_ff;
      w_in      = w_ff;
      pid_in    = pid_ff;
      ticks_in  = ticks_ff;
      idx_in    = idx_ff;
      cnt_in    = cnt_ff;
      found_in  = found_ff;
      n_in      = n_ff;
      ptr_in    = ptr_ff;
      prod_in   = prod_ff;
      status_in = status_ff;
      opid_in   = opid_ff;
      ouid_in   = ouid_ff;
      slice_in  = slice_ff;
      uids_in   = uids_ff;
      wts_in    = wts_ff;
      fill_in   = fill_ff;
      rdp_in    = rdp_ff;
      wrp_in    = wrp_ff;
      qb_in     = (csr_bus.valid) ? csr_bus.slice_unit : qb_ff;

      unique case (state_ff)
         S_IDLE: begin
            type_in   = req_bus.req_type;
            uid_in    = req_bus.user_id;
            w_in      = req_bus.weight;
            pid_in    = req_bus.proc_id;
            ticks_in  = req_bus.ticks_left;
            idx_in    = (req_bus.req_type == REQ_DISPATCH) ? UW'(ptr_ff) : '0;
            cnt_in    = '0;
            status_in = ST_NONE_READY;
            opid_in   = '0;
            ouid_in   = '0;
            slice_in  = '0;
         end
         S_LOOKUP: begin
            found_in = id_match && !at_end;
            if (!at_end && !id_match) begin
               idx_in = idx_ff + UW'(1);
            end
         end
         S_EXEC: begin
            if (found_ff) begin
               if (type_ff == REQ_ADD) begin
                  wts_in[sel] = w_ff;
                  status_in   = ST_ACCEPTED;
               end else if (queue_full) begin
                  status_in = ST_QUEUE_FULL;
               end else begin
                  wrp_in[sel]  = (wrp_ff[sel] == PW'(QUEUE_DEPTH - 1))
                                 ? '0 : wrp_ff[sel] + PW'(1);
                  fill_in[sel] = fill_ff[sel] + FW'(1);
                  status_in    = ST_ACCEPTED;
               end
            end else if (table_full) begin
               status_in = ST_TABLE_FULL;
            end else begin
               // new user lands at slot n
               uids_in[sel] = uid_ff;
               wts_in[sel]  = (type_ff == REQ_ADD) ? w_ff : WGT_DEFAULT;
               rdp_in[sel]  = '0;
               n_in         = n_ff + UW'(1);
               status_in    = ST_ACCEPTED;
               if (type_ff == REQ_ENQUEUE) begin
                  wrp_in[sel]  = (QUEUE_DEPTH == 1) ? '0 : PW'(1);
                  fill_in[sel] = FW'(1);
               end else begin
                  wrp_in[sel]  = '0;
                  fill_in[sel] = '0;
               end
            end
         end
         S_SEARCH: begin
            if (sel_ready) begin
               prod_in      = TICK_W'(qb_ff) * TICK_W'(wts_ff[sel]);
               ouid_in      = uids_ff[sel];
               rdp_in[sel]  = (rdp_ff[sel] == PW'(QUEUE_DEPTH - 1))
                              ? '0 : rdp_ff[sel] + PW'(1);
               fill_in[sel] = fill_ff[sel] - FW'(1);
               ptr_in       = idx_next_wrap[IW-1:0];
            end else begin
               cnt_in = cnt_ff + UW'(1);
               idx_in = idx_next_wrap;
            end
         end
         S_READ: begin
            status_in = ST_DISPATCHED;
            opid_in   = mem_rdata[PID_W-1:0];
            slice_in  = (prod_ff < rem) ? prod_ff : rem;
         end
         S_RESP: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         n_ff     <= '0;
         ptr_ff   <= '0;
         qb_ff    <= QB_RESET;
         for (int i = 0; i < MAX_USERS; i++) begin
            fill_ff[i] <= '0;
            rdp_ff[i]  <= '0;
            wrp_ff[i]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         n_ff     <= n_in;
         ptr_ff   <= ptr_in;
         qb_ff    <= qb_in;
         fill_ff  <= fill_in;
         rdp_ff   <= rdp_in;
         wrp_ff   <= wrp_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff   <= type_in;
      uid_ff    <= uid_in;
      w_ff      <= w_in;
      pid_ff    <= pid_in;
      ticks_ff  <= ticks_in;
      idx_ff    <= idx_in;
      cnt_ff    <= cnt_in;
      found_ff  <= found_in;
      prod_ff   <= prod_in;
      status_ff <= status_in;
      opid_ff   <= opid_in;
      ouid_ff   <= ouid_in;
      slice_ff  <= slice_in;
      uids_ff   <= uids_in;
      wts_ff    <= wts_in;
   end
endmodule

>>> src/pwrr_checker.sv
// ----------------------------------------------------------------------------
// pwrr_checker
// Port-level checks for the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module pwrr_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [2:0]                    rsp_status,
   input logic [pwrr_pkg::PID_W-1:0]    rsp_proc_id,
   input logic [pwrr_pkg::UID_W-1:0]    rsp_user_id,
   input logic [pwrr_pkg::TICK_W-1:0]   rsp_slice
);
   import pwrr_pkg::*;

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response beat right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_slice))
      else $error("stalled response beat changed");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("request taken while a response is pending");

   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_DISPATCHED
      |-> rsp_proc_id == '0 && rsp_user_id == '0 && rsp_slice == '0)
      else $error("nonzero payload on a non-dispatch response");

   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready stayed high after a request beat");
endmodule

bind per_user_weighted_round_robin pwrr_checker u_pwrr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_status  (rsp_bus.status),
   .rsp_proc_id (rsp_bus.out_proc_id),
   .rsp_user_id (rsp_bus.out_user_id),
   .rsp_slice   (rsp_bus.slice)
);

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives requests, CSR writes and response backpressure into the per-user
// weighted round-robin scheduler and checks every response beat against a
// behavioral model of the user table and per-user process FIFOs.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import pwrr_pkg::*;

   localparam int NUSR = MAX_USERS_DEF;
   localparam int QDEP = QUEUE_DEPTH_DEF;

   typedef struct packed {
      logic [2:0]        status;
      logic [PID_W-1:0]  pid;
      logic [UID_W-1:0]  uid;
      logic [TICK_W-1:0] slice;
   } grant_type;

   class sched_scoreboard;
      logic [QB_W-1:0]    quantum;
      logic [UID_W-1:0]   uids[NUSR];
      logic [WGT_W-1:0]   wgts[NUSR];
      logic [ENTRY_W-1:0] fifo[NUSR][$];
      int                 nusers;
      int                 rr_ptr;
      grant_type          pending[$];
      int                 errors;
      int                 checked;
      int                 n_disp;
      int                 n_full;

      function new();
         quantum = QB_RESET;
         nusers = 0;
         rr_ptr = 0;
         errors = 0;
         checked = 0;
         n_disp = 0;
         n_full = 0;
      endfunction

      function int find_user(logic [UID_W-1:0] u);
         for (int i = 0; i < nusers; i++)
            if (uids[i] == u) return i;
         return -1;
      endfunction

      function void note_request(logic [1:0] rt, logic [UID_W-1:0] u,
                                 logic [WGT_W-1:0] w, logic [PID_W-1:0] p,
                                 logic [TICK_W-1:0] t);
         grant_type g;
         int        idx;
         int        c;
         logic [31:0] qw;
         logic [TICK_W-1:0] rem;
         logic [ENTRY_W-1:0] e;
         g = '0;
         g.status = ST_NONE_READY;
         idx = find_user(u);
         if (rt == REQ_ADD) begin
            if (idx >= 0) begin
               wgts[idx] = w;
               g.status = ST_ACCEPTED;
            end else if (nusers >= NUSR) begin
               g.status = ST_TABLE_FULL;
            end else begin
               uids[nusers] = u;
               wgts[nusers] = w;
               fifo[nusers].delete();
               nusers++;
               g.status = ST_ACCEPTED;
            end
         end else if (rt == REQ_ENQUEUE) begin
            if (idx >= 0 && fifo[idx].size() >= QDEP) begin
               g.status = ST_QUEUE_FULL;
            end else if (idx < 0 && nusers >= NUSR) begin
               g.status = ST_TABLE_FULL;
            end else begin
               if (idx < 0) begin
                  idx = nusers;
                  uids[idx] = u;
                  wgts[idx] = WGT_DEFAULT;
                  fifo[idx].delete();
                  nusers++;
               end
               fifo[idx].push_back({t, p});
               g.status = ST_ACCEPTED;
            end
         end else if (rt == REQ_DISPATCH) begin
            c = -1;
            for (int k = 0; k < nusers; k++) begin
               idx = (rr_ptr + k) % nusers;
               if (fifo[idx].size() != 0) begin
                  c = idx;
                  break;
               end
            end
            if (c >= 0) begin
               e = fifo[c].pop_front();
               rem = e[ENTRY_W-1:PID_W];
               qw = 32'(quantum) * 32'(wgts[c]);
               g.status = ST_DISPATCHED;
               g.pid = e[PID_W-1:0];
               g.uid = uids[c];
               g.slice = (qw < 32'(rem)) ? qw[TICK_W-1:0] : rem;
               rr_ptr = (c + 1) % nusers;
               n_disp++;
            end
         end
         if (g.status == ST_TABLE_FULL || g.status == ST_QUEUE_FULL) n_full++;
         pending.push_back(g);
      endfunction

      function void check_result(grant_type a);
         grant_type x;
         checked++;
         if (pending.size() == 0) begin
            $error("response beat with nothing outstanding: %p", a);
            errors++;
            return;
         end
         x = pending.pop_front();
         if (a.status !== x.status) begin
            $error("status expected %0d actual %0d", x.status, a.status);
            errors++;
         end
         if (a.pid !== x.pid) begin
            $error("out_proc_id expected %0h actual %0h", x.pid, a.pid);
            errors++;
         end
         if (a.uid !== x.uid) begin
            $error("out_user_id expected %0h actual %0h", x.uid, a.uid);
            errors++;
         end
         if (a.slice !== x.slice) begin
            $error("slice expected %0h actual %0h", x.slice, a.slice);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   always #2 clock = ~clock;

   pwrr_req_if req_bus();
   pwrr_rsp_if rsp_bus();
   pwrr_csr_if csr_bus();

   per_user_weighted_round_robin DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source),
      .csr_bus (csr_bus.sink)
   );

   sched_scoreboard sb = new();
   longint cycles = 0;
   localparam longint CYCLE_LIMIT = 400000;
   bit rsp_stall_on = 1;
   logic [UID_W-1:0] uid_pool[8];

   initial begin
      req_bus.valid = 0;
      req_bus.req_type = '0;
      req_bus.user_id = '0;
      req_bus.weight = '0;
      req_bus.proc_id = '0;
      req_bus.ticks_left = '0;
      rsp_bus.ready = 0;
      csr_bus.valid = 0;
      csr_bus.slice_unit = '0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("per_user_weighted_round_robin verification failed");
         $finish;
      end
   end

   // response side: accept beats, random backpressure
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_result({rsp_bus.status, rsp_bus.out_proc_id,
                             rsp_bus.out_user_id, rsp_bus.slice});
      end
   end

   initial begin
      int w;
      @(posedge clock);
      while (1) begin
         w = rsp_stall_on ? $urandom_range(0, 11) : 0;
         if (w > 0) begin
            rsp_bus.ready <= 0;
            repeat (w) @(posedge clock);
         end
         rsp_bus.ready <= 1;
         @(posedge clock);
         while (!(rsp_bus.valid && !reset)) @(posedge clock);
      end
   end

   // valid stays high across back-to-back beats; it drops only for a gap
   task automatic send_req(logic [1:0] rt, logic [UID_W-1:0] u, logic [WGT_W-1:0] wt,
                           logic [PID_W-1:0] p, logic [TICK_W-1:0] t, bit gaps);
      int g;
      g = gaps ? $urandom_range(0, 11) : 0;
      if (g > 0) begin
         req_bus.valid <= 0;
         repeat (g) @(posedge clock);
      end
      req_bus.valid <= 1;
      req_bus.req_type <= rt;
      req_bus.user_id <= u;
      req_bus.weight <= wt;
      req_bus.proc_id <= p;
      req_bus.ticks_left <= t;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_request(rt, u, wt, p, t);
   endtask

   task automatic write_quantum(logic [QB_W-1:0] q);
      req_bus.valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_bus.valid <= 1;
      csr_bus.slice_unit <= q;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      sb.quantum = q;
      csr_bus.valid <= 0;
   endtask

   task automatic rand_req(bit gaps);
      int r;
      logic [UID_W-1:0] u;
      r = $urandom_range(0, 99);
      u = ($urandom_range(0, 9) == 0) ? UID_W'($urandom) : uid_pool[$urandom_range(0, 7)];
      if (r < 10)
         send_req(REQ_ADD, u, WGT_W'($urandom), PID_W'($urandom), TICK_W'($urandom), gaps);
      else if (r < 55)
         send_req(REQ_ENQUEUE, u, WGT_W'($urandom), PID_W'($urandom),
                  ($urandom_range(0, 1)) ? TICK_W'($urandom_range(0, 2000))
                                         : TICK_W'($urandom), gaps);
      else if (r < 97)
         send_req(REQ_DISPATCH, UID_W'($urandom), WGT_W'($urandom), PID_W'($urandom),
                  TICK_W'($urandom), gaps);
      else
         send_req(REQ_UNUSED, UID_W'($urandom), WGT_W'($urandom), PID_W'($urandom),
                  TICK_W'($urandom), gaps);
   endtask

   initial begin
      logic [QB_W-1:0] qset[5];
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty dispatch, unused code, extremes, zero weight, full queue
      send_req(REQ_DISPATCH, '0, '0, '0, '0, 0);
      send_req(REQ_UNUSED, '1, '1, '1, '1, 0);
      send_req(REQ_ADD, 16'hFFFF, 8'hFF, '0, '0, 0);
      send_req(REQ_ADD, 16'h0000, 8'h00, '0, '0, 0);
      send_req(REQ_ENQUEUE, 16'hFFFF, '0, 16'hFFFF, 24'hFFFFFF, 0);
      send_req(REQ_ENQUEUE, 16'h0000, '0, 16'h0000, 24'h000000, 0);
      send_req(REQ_ENQUEUE, 16'h0000, '0, 16'h1234, 24'h000100, 0);
      send_req(REQ_ENQUEUE, 16'h0000, '0, 16'h5678, 24'h000005, 0);
      send_req(REQ_ADD, 16'hFFFF, 8'h80, '0, '0, 0);
      for (int i = 0; i < 4; i++)
         send_req(REQ_DISPATCH, '0, '0, '0, '0, 0);
      send_req(REQ_DISPATCH, '0, '0, '0, '0, 0);
      for (int i = 0; i < 17; i++)
         send_req(REQ_ENQUEUE, 16'hABCD, '0, PID_W'(i), TICK_W'(i * 3), 0);

      qset = '{16'hFFFF, 16'd1, 16'd7, 16'd0, 16'd300};
      for (int ph = 0; ph < 5; ph++) begin
         write_quantum(qset[ph]);
         rsp_stall_on = (ph != 2);
         for (int i = 0; i < 8; i++) uid_pool[i] = UID_W'($urandom);
         for (int n = 0; n < 190; n++) rand_req(ph != 1);
         // burst that fills the user table
         if (ph == 3)
            for (int n = 0; n < 20; n++)
               send_req(REQ_ENQUEUE, UID_W'($urandom), '0, PID_W'($urandom),
                        TICK_W'($urandom), 1);
         for (int n = 0; n < 30; n++)
            send_req(REQ_DISPATCH, '0, '0, '0, '0, 1);
      end
      req_bus.valid <= 0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("checked %0d responses: %0d dispatches, %0d table/queue full cases",
               sb.checked, sb.n_disp, sb.n_full);
      $display("five quantum settings incl. 0 and 0xFFFF, random stalls on both channels");
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("per_user_weighted_round_robin verification clean");
      else
         $display("per_user_weighted_round_robin verification failed");
      $finish;
   end
endmodule
